### hdl/escape_time_fractal_pixel_top_defines.svh
// Assertion macros shared by the fractal pixel block.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_TOP_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_TOP_DEFINES_SVH

// Implication that must hold at every clock edge out of reset.
`define EFP_ASSERT_IMPL(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define EFP_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/efp_pkg.sv
package efp_pkg;

  // Default image size
  localparam int IMAGE_WIDTH_DEF  = 1024;
  localparam int IMAGE_HEIGHT_DEF = 1024;

  // Fixed field widths
  localparam int Q_W         = 32;
  localparam int PROD_W      = 2 * Q_W;
  localparam int STEP_W      = 31;
  localparam int PIX_W       = 10;
  localparam int COUNT_W     = 16;
  localparam int CFG_INDEX_W = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_RE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_IM  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_STEP = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_JULIA_MODE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CONST_RE   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CONST_IM   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ITER_LIMIT = 3'd6;

  // Register reset values
  localparam logic [STEP_W-1:0]  PIXEL_STEP_RST = 31'd1048576;
  localparam logic [COUNT_W-1:0] ITER_LIMIT_RST = 16'd128;

  // Escape radius squared, 4 in Q8.56
  localparam logic [PROD_W-1:0] ESCAPE_LIM = 64'h0400_0000_0000_0000;

  // Q4.28 range
  localparam logic signed [PROD_W-1:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] Q_MIN = -64'sd2147483648;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_RE,
    ST_MAP_IM,
    ST_INIT,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_CROSS,
    ST_UPD
  } efp_state_t;

  // Clamp a wide signed value into Q4.28
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > Q_MAX) begin
      r = Q_MAX[Q_W-1:0];
    end else if (v < Q_MIN) begin
      r = Q_MIN[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/escape_time_fractal_pixel_top.sv
// After a start transfer the sequencer maps the pixel, loads z and c and runs N iterations
// before the done strobe, N = iterations done (0 to iter_limit); the first iteration is
// always attempted unless the limit is 0. One pixel at a time, start taken only while busy
// is low; one shared 32x32 multiplier takes three products per iteration.
// Reset (rst, synchronous): sequencer idle, done cleared, configuration registers back to their defaults.
// done pulses for one cycle with iter_count while busy is low; the receiver cannot stall it.
`include "escape_time_fractal_pixel_top_defines.svh"

module escape_time_fractal_pixel_top #(
  parameter int IMAGE_WIDTH  = efp_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = efp_pkg::IMAGE_HEIGHT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [efp_pkg::PIX_W-1:0]             pixel_col,
  input  logic [efp_pkg::PIX_W-1:0]             pixel_row,
  input  logic                                  cfg_we,
  input  logic [efp_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [efp_pkg::Q_W-1:0]               cfg_data,
  output logic                                  done,
  output logic [efp_pkg::COUNT_W-1:0]           iter_count
);
  import efp_pkg::*;

  localparam logic signed [Q_W-1:0] HALF_W = Q_W'(IMAGE_WIDTH / 2);
  localparam logic signed [Q_W-1:0] HALF_H = Q_W'(IMAGE_HEIGHT / 2);

  // Configuration registers
  logic signed [Q_W-1:0]     center_re;
  logic signed [Q_W-1:0]     center_im;
  logic [STEP_W-1:0]         pixel_step;
  logic                      julia_mode;
  logic signed [Q_W-1:0]     const_re;
  logic signed [Q_W-1:0]     const_im;
  logic [COUNT_W-1:0]        iter_limit;

  // Sequencer and datapath registers
  efp_state_t                state;
  efp_state_t                state_next;
  logic [PIX_W-1:0]          col;
  logic [PIX_W-1:0]          row;
  logic signed [Q_W-1:0]     pt_re;
  logic signed [Q_W-1:0]     zr;
  logic signed [Q_W-1:0]     zi;
  logic signed [Q_W-1:0]     cr;
  logic signed [Q_W-1:0]     ci;
  logic signed [PROD_W-1:0]  rr;
  logic signed [PROD_W-1:0]  prod;
  logic [COUNT_W-1:0]        count;

  // Combinational signals
  logic signed [Q_W-1:0]     mul_a;
  logic signed [Q_W-1:0]     mul_b;
  logic signed [Q_W-1:0]     d_col;
  logic signed [Q_W-1:0]     d_row;
  logic signed [Q_W-1:0]     map_re;
  logic signed [Q_W-1:0]     map_im;
  logic [PROD_W-1:0]         len;
  logic                      finish;
  logic signed [PROD_W-1:0]  diff;
  logic signed [Q_W-1:0]     new_re;
  logic signed [Q_W-1:0]     new_im;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_re  <= '0;
      center_im  <= '0;
      pixel_step <= PIXEL_STEP_RST;
      julia_mode <= 1'b0;
      const_re   <= '0;
      const_im   <= '0;
      iter_limit <= ITER_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_RE:  center_re  <= cfg_data;
        REG_CENTER_IM:  center_im  <= cfg_data;
        REG_PIXEL_STEP: pixel_step <= cfg_data[STEP_W-1:0];
        REG_JULIA_MODE: julia_mode <= cfg_data[0];
        REG_CONST_RE:   const_re   <= cfg_data;
        REG_CONST_IM:   const_im   <= cfg_data;
        REG_ITER_LIMIT: iter_limit <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pixel offsets from the image center
  assign d_col = signed'({{(Q_W-PIX_W){1'b0}}, col}) - HALF_W;
  assign d_row = signed'({{(Q_W-PIX_W){1'b0}}, row}) - HALF_H;

  // Mapped point parts, taken from the product register
  assign map_re = sat_q(prod + PROD_W'(center_re));
  assign map_im = sat_q(prod + PROD_W'(center_im));

  // Escape test on the squares of the current z
  assign len    = unsigned'(rr) + unsigned'(prod);
  assign finish = (count >= iter_limit) || ((count != '0) && (len >= ESCAPE_LIM));

  // Next z: real part from the squares, imaginary part from the cross product
  assign diff   = rr - prod;
  assign new_re = sat_q((diff >>> 28) + PROD_W'(cr));
  assign new_im = sat_q((prod >>> 27) + PROD_W'(ci));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_MAP_RE;
      ST_MAP_RE: state_next = ST_MAP_IM;
      ST_MAP_IM: state_next = ST_INIT;
      ST_INIT:   state_next = ST_SQ_RE;
      ST_SQ_RE:  state_next = ST_SQ_IM;
      ST_SQ_IM:  state_next = ST_CROSS;
      ST_CROSS:  state_next = finish ? ST_IDLE : ST_UPD;
      ST_UPD:    state_next = ST_SQ_RE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs: busy flag and multiplier operand select
  always_comb begin
    busy  = (state != ST_IDLE);
    mul_a = zr;
    mul_b = zr;
    case (state)
      ST_MAP_RE: begin
        mul_a = d_col;
        mul_b = signed'({1'b0, pixel_step});
      end
      ST_MAP_IM: begin
        mul_a = d_row;
        mul_b = signed'({1'b0, pixel_step});
      end
      ST_SQ_RE: begin
        mul_a = zr;
        mul_b = zr;
      end
      ST_SQ_IM: begin
        mul_a = zi;
        mul_b = zi;
      end
      ST_CROSS: begin
        mul_a = zr;
        mul_b = zi;
      end
      default: begin
        mul_a = zr;
        mul_b = zr;
      end
    endcase
  end

  // Shared multiplier with registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Sequencer state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_CROSS) && finish;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        // capture the pixel on a start transfer
        if (start) begin
          col <= pixel_col;
          row <= pixel_row;
        end
      end
      ST_MAP_IM: begin
        pt_re <= map_re;
      end
      ST_INIT: begin
        count <= '0;
        if (julia_mode) begin
          zr <= pt_re;
          zi <= map_im;
          cr <= const_re;
          ci <= const_im;
        end else begin
          zr <= '0;
          zi <= '0;
          cr <= pt_re;
          ci <= map_im;
        end
      end
      ST_SQ_IM: begin
        rr <= prod;
      end
      ST_CROSS: begin
        // zr has already fed the cross product, so it can advance now
        if (finish) begin
          iter_count <= count;
        end else begin
          zr <= new_re;
        end
      end
      ST_UPD: begin
        zi    <= new_im;
        count <= count + 1'b1;
      end
      default: ;
    endcase
  end

  // Checks
  `EFP_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `EFP_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "start transfer not taken")
  `EFP_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result strobe longer than a cycle")

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import efp_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic signed [63:0] HALF_W = IMAGE_WIDTH_DEF / 2;
  localparam logic signed [63:0] HALF_H = IMAGE_HEIGHT_DEF / 2;
  localparam logic [63:0] ESCAPE_SQ = 64'h0400_0000_0000_0000;

  typedef enum logic {DO_PIXEL, DO_WRITE} dir_kind_t;

  typedef struct {
    dir_kind_t              kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [Q_W-1:0]         data;
    logic [PIX_W-1:0]       col;
    logic [PIX_W-1:0]       row;
    bit                     typed;
    logic [COUNT_W-1:0]     want;
  } dir_row_t;

  typedef struct {
    logic [PIX_W-1:0]   col;
    logic [PIX_W-1:0]   row;
    logic [COUNT_W-1:0] count;
  } pixel_due_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [PIX_W-1:0] pixel_col = '0;
  logic [PIX_W-1:0] pixel_row = '0;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [Q_W-1:0] cfg_data = '0;
  logic busy;
  logic done;
  logic [COUNT_W-1:0] iter_count;

  // Local copy of the view and iteration settings
  logic signed [Q_W-1:0] view_re = '0;
  logic signed [Q_W-1:0] view_im = '0;
  logic [STEP_W-1:0]     step_q = 31'd1048576;
  logic                  julia_on = 1'b0;
  logic signed [Q_W-1:0] seed_re = '0;
  logic signed [Q_W-1:0] seed_im = '0;
  logic [COUNT_W-1:0]    iter_cap = 16'd128;

  // Sideband that rides with start: a count typed into the table
  bit                 use_typed = 1'b0;
  logic [COUNT_W-1:0] typed_count = '0;

  pixel_due_t counts_due[$];
  pixel_due_t seen;
  dir_row_t   script[$];
  int         idle_pct = 0;
  int         errors = 0;

  escape_time_fractal_pixel_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .pixel_col  (pixel_col),
    .pixel_row  (pixel_row),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .iter_count (iter_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp to the Q4.28 range
  function automatic logic signed [31:0] clamp_q(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Map one pixel index to a Q4.28 coordinate around the view center
  function automatic logic signed [31:0] pixel_to_q(input logic [PIX_W-1:0] pos,
                                                   input logic signed [63:0] half,
                                                   input logic signed [31:0] ctr);
    logic signed [63:0] d;
    logic signed [63:0] s;
    logic signed [63:0] c64;
    d = $signed({54'd0, pos}) - half;
    s = $signed({33'd0, step_q});
    c64 = ctr;
    return clamp_q(d * s + c64);
  endfunction

  // Iterate z = z*z + c until escape or the limit; return the count
  function automatic logic [COUNT_W-1:0] escape_count(input logic [PIX_W-1:0] col,
                                                     input logic [PIX_W-1:0] row);
    logic signed [31:0] pr;
    logic signed [31:0] pi;
    logic signed [63:0] zr;
    logic signed [63:0] zi;
    logic signed [63:0] cr;
    logic signed [63:0] ci;
    logic signed [63:0] rr;
    logic signed [63:0] ii;
    logic signed [63:0] ri;
    logic [63:0] mag;
    logic [COUNT_W-1:0] n;
    pr = pixel_to_q(col, HALF_W, view_re);
    pi = pixel_to_q(row, HALF_H, view_im);
    if (julia_on) begin
      zr = pr;
      zi = pi;
      cr = seed_re;
      ci = seed_im;
    end else begin
      zr = 0;
      zi = 0;
      cr = pr;
      ci = pi;
    end
    n = '0;
    mag = '0;
    while (n < iter_cap && mag < ESCAPE_SQ) begin
      rr = zr * zr;
      ii = zi * zi;
      ri = zr * zi;
      zr = clamp_q(((rr - ii) >>> 28) + cr);
      zi = clamp_q((ri >>> 27) + ci);
      mag = (zr * zr) + (zi * zi);
      n = n + 1'b1;
    end
    return n;
  endfunction

  // Write one register and mirror it into the local settings
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [Q_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CENTER_RE:  view_re = val;
      REG_CENTER_IM:  view_im = val;
      REG_PIXEL_STEP: step_q = val[STEP_W-1:0];
      REG_JULIA_MODE: julia_on = val[0];
      REG_CONST_RE:   seed_re = val;
      REG_CONST_IM:   seed_im = val;
      REG_ITER_LIMIT: iter_cap = val[COUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drop start and hold until every pixel in flight has reported
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (counts_due.size() != 0 || busy) @(posedge clk);
  endtask

  // Offer one pixel, dropping start on random cycles; return at the edge that takes it
  task automatic send_pixel(input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] r,
                            input bit typed, input logic [COUNT_W-1:0] want);
    bit go;
    bit taken;
    pixel_col <= c;
    pixel_row <= r;
    use_typed <= typed;
    typed_count <= want;
    taken = 1'b0;
    while (!taken) begin
      go = ($urandom_range(99) >= idle_pct);
      start <= go;
      @(posedge clk);
      taken = go && !busy;
    end
  endtask

  // Check each count against the oldest pending pixel, then log new transfers
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (counts_due.size() == 0) begin
          $display("%0t ns: unexpected done, iter_count %0d", $time, iter_count);
          errors++;
        end else begin
          seen = counts_due.pop_front();
          if (iter_count !== seen.count) begin
            $display("%0t ns: pixel (%0d,%0d) iter_count expected %0d, got %0d",
                     $time, seen.col, seen.row, seen.count, iter_count);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        seen.col = pixel_col;
        seen.row = pixel_row;
        seen.count = use_typed ? typed_count : escape_count(pixel_col, pixel_row);
        counts_due.push_back(seen);
      end
    end
  end

  initial begin
    int k;
    int ph;
    int n;
    logic [31:0] cre;
    logic [31:0] cim;
    logic [31:0] stp;
    logic [31:0] kre;
    logic [31:0] kim;
    logic [15:0] lim;

    // Directed table: reset view, limits, saturation, zero step, Julia
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd512, 10'd512, 1'b1, 16'd128});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd0, 10'd0, 1'b1, 16'd1});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd1023, 10'd1023, 1'b0, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd0, 10'd512, 1'b0, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd448, 10'd512, 1'b0, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd320, 10'd512, 1'b0, 16'd0});
    script.push_back('{DO_WRITE, REG_ITER_LIMIT, 32'd0, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd512, 10'd512, 1'b1, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd1023, 10'd0, 1'b1, 16'd0});
    script.push_back('{DO_WRITE, REG_ITER_LIMIT, 32'd1, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd512, 10'd512, 1'b1, 16'd1});
    script.push_back('{DO_WRITE, REG_ITER_LIMIT, 32'd32768, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd512, 10'd512, 1'b1, 16'd32768});
    script.push_back('{DO_WRITE, REG_ITER_LIMIT, 32'd65535, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd589, 10'd512, 1'b0, 16'd0});
    script.push_back('{DO_WRITE, REG_ITER_LIMIT, 32'd200, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_WRITE, REG_CENTER_RE, 32'h7FFF_FFFF, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_WRITE, REG_PIXEL_STEP, 32'h7FFF_FFFF, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd1023, 10'd512, 1'b1, 16'd1});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd0, 10'd512, 1'b1, 16'd1});
    script.push_back('{DO_WRITE, REG_CENTER_RE, 32'h8000_0000, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_WRITE, REG_CENTER_IM, 32'h8000_0000, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd1023, 10'd1023, 1'b0, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd512, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_WRITE, REG_PIXEL_STEP, 32'd0, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_WRITE, REG_CENTER_RE, 32'd0, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_WRITE, REG_CENTER_IM, 32'd0, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd0, 10'd0, 1'b1, 16'd200});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd1023, 10'd1023, 1'b1, 16'd200});
    // Write to the unused index must leave the zero step in place
    script.push_back('{DO_WRITE, REG_UNUSED, 32'hFFFF_FFFF, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd682, 10'd341, 1'b1, 16'd200});
    script.push_back('{DO_WRITE, REG_PIXEL_STEP, 32'h0010_0000, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_WRITE, REG_JULIA_MODE, 32'd1, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_WRITE, REG_CONST_RE, 32'hF999_999A, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_WRITE, REG_CONST_IM, 32'h0999_999A, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd512, 10'd512, 1'b0, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd400, 10'd600, 1'b0, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd1023, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_WRITE, REG_CONST_RE, 32'h7FFF_FFFF, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_WRITE, REG_CONST_IM, 32'h8000_0000, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd512, 10'd512, 1'b1, 16'd1});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd0, 10'd1023, 1'b0, 16'd0});
    script.push_back('{DO_WRITE, REG_JULIA_MODE, 32'd0, 10'd0, 10'd0, 1'b0, 16'd0});
    script.push_back('{DO_PIXEL, REG_UNUSED, 32'd0, 10'd700, 10'd300, 1'b0, 16'd0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table back to back
    for (k = 0; k < script.size(); k++) begin
      if (script[k].kind == DO_WRITE) begin
        settle();
        write_reg(script[k].idx, script[k].data);
      end else begin
        send_pixel(script[k].col, script[k].row, script[k].typed, script[k].want);
      end
    end

    // Random views, one setting per phase, sender gaps rotating per phase
    for (ph = 0; ph < 8; ph++) begin
      settle();
      case ($urandom_range(0, 5))
        0: begin
          cre = 32'h7FFF_FFFF;
          cim = 32'h8000_0000;
        end
        1: begin
          cre = $urandom;
          cim = $urandom;
        end
        default: begin
          cre = int'($urandom_range(0, 805306368)) - 536870912;
          cim = int'($urandom_range(0, 536870912)) - 268435456;
        end
      endcase
      case ($urandom_range(0, 7))
        0: stp = $urandom;
        1: stp = 32'd0;
        2: stp = 32'hFFFF_FFFF;
        default: stp = {1'($urandom), 31'($urandom_range(1, 1 << 20))};
      endcase
      if ($urandom_range(0, 3) == 0) begin
        kre = $urandom;
        kim = $urandom;
      end else begin
        kre = int'($urandom_range(0, 536870912)) - 268435456;
        kim = int'($urandom_range(0, 536870912)) - 268435456;
      end
      lim = ($urandom_range(0, 11) == 0) ? 16'd0 : 16'($urandom_range(1, 160));
      write_reg(REG_CENTER_RE, cre);
      write_reg(REG_CENTER_IM, cim);
      write_reg(REG_PIXEL_STEP, stp);
      write_reg(REG_JULIA_MODE, ($urandom & 32'hFFFF_FFFE) | 32'(ph % 2));
      write_reg(REG_CONST_RE, kre);
      write_reg(REG_CONST_IM, kim);
      write_reg(REG_ITER_LIMIT, {16'($urandom), lim});
      write_reg(REG_UNUSED, $urandom);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 76;
        default: idle_pct = 35;
      endcase
      for (n = 0; n < 131; n++) begin
        send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), 1'b0, 16'd0);
      end
    end

    // Drain and leave room for any stray strobe
    settle();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #(50_000_000);
    $display("%0t ns: timeout with %0d pixels pending", $time, counts_due.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### escape_time_fractal_pixel_top.f
+incdir+hdl
hdl/efp_pkg.sv
hdl/escape_time_fractal_pixel_top.sv
tb/sv/tb.sv
